// ===== design/ospa_pkg.sv =====
// ----------------------------------------------------------------------------
// ospa_pkg: shared types and codes for the ordered slot pool allocator
// Holds the operation codes passed from the controller to the datapath,
// the status flags passed back, and the result status codes.
// ----------------------------------------------------------------------------
package ospa_pkg;

    // result status codes
    localparam logic [1:0] STATUS_OK        = 2'd0;
    localparam logic [1:0] STATUS_NOT_FOUND = 2'd1;
    localparam logic [1:0] STATUS_EMPTY     = 2'd2;

    // request codes
    localparam logic FUNC_ALLOC = 1'b0;
    localparam logic FUNC_FREE  = 1'b1;

    // datapath operation codes
    localparam logic [3:0] OP_NONE        = 4'd0;
    localparam logic [3:0] OP_LOAD        = 4'd1;
    localparam logic [3:0] OP_ALLOC_START = 4'd2;
    localparam logic [3:0] OP_FREE_START  = 4'd3;
    localparam logic [3:0] OP_EMPTY       = 4'd4;
    localparam logic [3:0] OP_NOT_FOUND   = 4'd5;
    localparam logic [3:0] OP_POP         = 4'd6;
    localparam logic [3:0] OP_APPEND      = 4'd7;
    localparam logic [3:0] OP_WALK_NEXT   = 4'd8;
    localparam logic [3:0] OP_UNLINK      = 4'd9;
    localparam logic [3:0] OP_PUSH        = 4'd10;
    localparam logic [3:0] OP_EMIT        = 4'd11;

    typedef logic [3:0] op_t;

    // controller command
    typedef struct packed {
        op_t op;
    } cmd_t;

    // datapath flags seen by the controller
    typedef struct packed {
        logic func_free;   // latched request is a free
        logic free_empty;  // free stack is empty
        logic used_empty;  // in-use list is empty
        logic tail_valid;  // in-use tail names a slot
        logic cur_match;   // walk cursor equals the requested slot
        logic nxt_none;    // link read at the cursor ends the list
        logic steps_done;  // walk has used its whole step budget
        logic out_ready;   // output register can take a word
    } flags_t;

endpackage

// ===== design/ospa_link_mem.sv =====
// ----------------------------------------------------------------------------
// ospa_link_mem: link array of the slot pool
// One write port, one read port with registered data. Per-entry valid bits
// stand in for the reset contents: an unwritten entry i reads as i+1.
// ----------------------------------------------------------------------------
module ospa_link_mem #(
    parameter int DEPTH  = 32,
    parameter int IDX_W  = 5,
    parameter int LINK_W = 6
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              wr_en,
    input  logic [IDX_W-1:0]  wr_addr,
    input  logic [LINK_W-1:0] wr_data,
    input  logic              rd_en,
    input  logic [IDX_W-1:0]  rd_addr,
    output logic [LINK_W-1:0] rd_data
);

    logic [LINK_W-1:0] mem [DEPTH];
    logic [DEPTH-1:0]  valid_reg;
    logic [LINK_W-1:0] rd_q_reg;
    logic              rd_valid_reg;
    logic [IDX_W-1:0]  rd_addr_reg;

    // storage write and registered read
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_q_reg    <= mem[rd_addr];
            rd_addr_reg <= rd_addr;
        end
    end

    // valid bits, cleared at reset
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end else begin
            if (wr_en) begin
                valid_reg[wr_addr] <= 1'b1;
            end
            if (rd_en) begin
                rd_valid_reg <= valid_reg[rd_addr];
            end
        end
    end

    // unwritten entry reads as its reset link
    assign rd_data = rd_valid_reg ? rd_q_reg
                                  : LINK_W'(rd_addr_reg) + LINK_W'(1);

endmodule

// ===== design/ospa_ctrl.sv =====
// ----------------------------------------------------------------------------
// ospa_ctrl: request sequencer
// Steps one request through dispatch, pop/append or list walk/unlink/push,
// and the hand-off to the output register.
// ----------------------------------------------------------------------------
module ospa_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  ospa_pkg::flags_t  flags,
    output ospa_pkg::cmd_t    cmd
);
    import ospa_pkg::*;

    localparam logic [2:0] ST_IDLE     = 3'd0;
    localparam logic [2:0] ST_DISPATCH = 3'd1;
    localparam logic [2:0] ST_POP      = 3'd2;
    localparam logic [2:0] ST_APPEND   = 3'd3;
    localparam logic [2:0] ST_WALK     = 3'd4;
    localparam logic [2:0] ST_PUSH     = 3'd5;
    localparam logic [2:0] ST_EMIT     = 3'd6;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    assign s_tready = (state_reg == ST_IDLE);

    // next state and datapath command
    always_comb begin
        state_next = state_reg;
        cmd.op     = OP_NONE;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd.op     = OP_LOAD;
                    state_next = ST_DISPATCH;
                end
            end
            ST_DISPATCH: begin
                if (flags.func_free) begin
                    if (flags.used_empty) begin
                        cmd.op     = OP_NOT_FOUND;
                        state_next = ST_EMIT;
                    end else begin
                        cmd.op     = OP_FREE_START;
                        state_next = ST_WALK;
                    end
                end else if (flags.free_empty) begin
                    cmd.op     = OP_EMPTY;
                    state_next = ST_EMIT;
                end else begin
                    cmd.op     = OP_ALLOC_START;
                    state_next = ST_POP;
                end
            end
            ST_POP: begin
                cmd.op     = OP_POP;
                state_next = flags.tail_valid ? ST_APPEND : ST_EMIT;
            end
            ST_APPEND: begin
                cmd.op     = OP_APPEND;
                state_next = ST_EMIT;
            end
            ST_WALK: begin
                if (flags.cur_match) begin
                    cmd.op     = OP_UNLINK;
                    state_next = ST_PUSH;
                end else if (flags.nxt_none || flags.steps_done) begin
                    cmd.op     = OP_NOT_FOUND;
                    state_next = ST_EMIT;
                end else begin
                    cmd.op     = OP_WALK_NEXT;
                end
            end
            ST_PUSH: begin
                cmd.op     = OP_PUSH;
                state_next = ST_EMIT;
            end
            ST_EMIT: begin
                if (flags.out_ready) begin
                    cmd.op     = OP_EMIT;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // state register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== design/ospa_dpath.sv =====
// ----------------------------------------------------------------------------
// ospa_dpath: pool datapath
// Chain heads, walk cursor, result and output registers around the link
// memory; each controller operation updates them.
// ----------------------------------------------------------------------------
module ospa_dpath #(
    parameter int POOL_SIZE = 32
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  ospa_pkg::cmd_t   cmd,
    output ospa_pkg::flags_t flags,
    input  logic             in_func,
    input  logic [4:0]       in_slot_number,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [1:0]       out_status,
    output logic [4:0]       out_slot
);
    import ospa_pkg::*;

    localparam int IDX_W  = $clog2(POOL_SIZE);
    localparam int LINK_W = $clog2(POOL_SIZE + 1);
    localparam int CMP_W  = LINK_W + 5;
    localparam logic [LINK_W-1:0] NONE_LINK = LINK_W'(POOL_SIZE);

    logic              func_reg;
    logic [4:0]        target_reg;
    logic [LINK_W-1:0] free_head_reg, free_head_next;
    logic [LINK_W-1:0] used_head_reg, used_head_next;
    logic [LINK_W-1:0] used_tail_reg, used_tail_next;
    logic [LINK_W-1:0] cur_reg, cur_next;
    logic [LINK_W-1:0] prev_reg, prev_next;
    logic [LINK_W-1:0] steps_reg, steps_next;
    logic [1:0]        res_status_reg, res_status_next;
    logic [IDX_W-1:0]  res_idx_reg, res_idx_next;
    logic              out_valid_reg, out_valid_next;
    logic [1:0]        out_status_reg, out_status_next;
    logic [4:0]        out_slot_reg, out_slot_next;

    logic              wr_en;
    logic [IDX_W-1:0]  wr_addr;
    logic [LINK_W-1:0] wr_data;
    logic              rd_en;
    logic [IDX_W-1:0]  rd_addr;
    logic [LINK_W-1:0] rd_link;
    logic [IDX_W+4:0]  res_ext;

    function automatic logic is_slot(input logic [LINK_W-1:0] v);
        return v < NONE_LINK;
    endfunction

    ospa_link_mem #(
        .DEPTH  (POOL_SIZE),
        .IDX_W  (IDX_W),
        .LINK_W (LINK_W)
    ) u_link_mem (
        .aclk    (aclk),
        .aresetn (aresetn),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_link)
    );

    // status flags for the controller
    always_comb begin
        flags.func_free  = (func_reg == FUNC_FREE);
        flags.free_empty = !is_slot(free_head_reg);
        flags.used_empty = !is_slot(used_head_reg);
        flags.tail_valid = is_slot(used_tail_reg);
        flags.cur_match  = (CMP_W'(cur_reg) == CMP_W'(target_reg));
        flags.nxt_none   = !is_slot(rd_link);
        flags.steps_done = (steps_reg == NONE_LINK);
        flags.out_ready  = !out_valid_reg || out_ready;
    end

    // result slot masked to the five-bit field
    assign res_ext = {5'd0, res_idx_reg};

    // operation decode
    always_comb begin
        free_head_next  = free_head_reg;
        used_head_next  = used_head_reg;
        used_tail_next  = used_tail_reg;
        cur_next        = cur_reg;
        prev_next       = prev_reg;
        steps_next      = steps_reg;
        res_status_next = res_status_reg;
        res_idx_next    = res_idx_reg;
        out_status_next = out_status_reg;
        out_slot_next   = out_slot_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        wr_en           = 1'b0;
        wr_addr         = '0;
        wr_data         = '0;
        rd_en           = 1'b0;
        rd_addr         = '0;
        case (cmd.op)
            OP_ALLOC_START: begin
                rd_en   = 1'b1;
                rd_addr = free_head_reg[IDX_W-1:0];
            end
            OP_FREE_START: begin
                rd_en      = 1'b1;
                rd_addr    = used_head_reg[IDX_W-1:0];
                cur_next   = used_head_reg;
                prev_next  = NONE_LINK;
                steps_next = LINK_W'(1);
            end
            OP_EMPTY: begin
                res_status_next = STATUS_EMPTY;
                res_idx_next    = '0;
            end
            OP_NOT_FOUND: begin
                res_status_next = STATUS_NOT_FOUND;
                res_idx_next    = '0;
            end
            OP_POP: begin
                // take the top of the free stack and end its chain
                free_head_next  = rd_link;
                wr_en           = 1'b1;
                wr_addr         = free_head_reg[IDX_W-1:0];
                wr_data         = NONE_LINK;
                res_idx_next    = free_head_reg[IDX_W-1:0];
                res_status_next = STATUS_OK;
                if (!is_slot(used_tail_reg)) begin
                    used_head_next = free_head_reg;
                    used_tail_next = free_head_reg;
                end
            end
            OP_APPEND: begin
                wr_en          = 1'b1;
                wr_addr        = used_tail_reg[IDX_W-1:0];
                wr_data        = LINK_W'(res_idx_reg);
                used_tail_next = LINK_W'(res_idx_reg);
            end
            OP_WALK_NEXT: begin
                rd_en      = 1'b1;
                rd_addr    = rd_link[IDX_W-1:0];
                prev_next  = cur_reg;
                cur_next   = rd_link;
                steps_next = steps_reg + LINK_W'(1);
            end
            OP_UNLINK: begin
                // bypass the cursor slot, fixing head and tail
                if (is_slot(prev_reg)) begin
                    wr_en   = 1'b1;
                    wr_addr = prev_reg[IDX_W-1:0];
                    wr_data = rd_link;
                    if (used_tail_reg == cur_reg) begin
                        used_tail_next = prev_reg;
                    end
                end else begin
                    used_head_next = rd_link;
                    if (!is_slot(rd_link)) begin
                        used_tail_next = NONE_LINK;
                    end
                end
            end
            OP_PUSH: begin
                wr_en           = 1'b1;
                wr_addr         = cur_reg[IDX_W-1:0];
                wr_data         = free_head_reg;
                free_head_next  = cur_reg;
                res_idx_next    = cur_reg[IDX_W-1:0];
                res_status_next = STATUS_OK;
            end
            OP_EMIT: begin
                out_valid_next  = 1'b1;
                out_status_next = res_status_reg;
                out_slot_next   = res_ext[4:0];
            end
            default: begin
            end
        endcase
    end

    // request latch, captured at input accept
    always_ff @(posedge aclk) begin
        if (cmd.op == OP_LOAD) begin
            func_reg   <= in_func;
            target_reg <= in_slot_number;
        end
    end

    // pool heads and output valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            free_head_reg <= '0;
            used_head_reg <= NONE_LINK;
            used_tail_reg <= NONE_LINK;
            out_valid_reg <= 1'b0;
        end else begin
            free_head_reg <= free_head_next;
            used_head_reg <= used_head_next;
            used_tail_reg <= used_tail_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // walk cursor, result and output payload
    always_ff @(posedge aclk) begin
        cur_reg        <= cur_next;
        prev_reg       <= prev_next;
        steps_reg      <= steps_next;
        res_status_reg <= res_status_next;
        res_idx_reg    <= res_idx_next;
        out_status_reg <= out_status_next;
        out_slot_reg   <= out_slot_next;
    end

    assign out_valid  = out_valid_reg;
    assign out_status = out_status_reg;
    assign out_slot   = out_slot_reg;

endmodule

// ===== design/ordered_slot_pool_allocator.sv =====
// ----------------------------------------------------------------------------
// ordered_slot_pool_allocator: slot allocator with an ordered in-use list
// Free slots sit on a LIFO stack, slots in use on a list in allocation
// order, both held in one link memory.
// ----------------------------------------------------------------------------
// Usage:
//   Input stream: s_tuser selects the request (0 allocate, 1 free) and
//   s_tdata[4:0] names the slot to free. Each request gives exactly one
//   result word: m_tuser carries the status (0 ok, 1 not in use, 2 pool
//   empty) and m_tdata[4:0] the slot, zero on error.
//   One request is in work at a time; s_tready is high only between them.
//   Allocate: dispatch, pop and, unless the in-use list is empty, append,
//   then emit (pop and append each take the one link memory write port).
//   Free: dispatch, a walk of the in-use list from its head (one link
//   memory read per list step), unlink, push and emit; a miss ends when the
//   walk reaches the end of the list or has used its whole step budget.
//   Reset (aresetn low, synchronous) empties the in-use list and puts every
//   slot on the free stack in ascending order; no clearing pass is needed.
//   The result sits in an output register: a new request is accepted while
//   it waits, and the block stalls only when its next result is ready and
//   m_tready is still low.
// ----------------------------------------------------------------------------
module ordered_slot_pool_allocator #(
    parameter int POOL_SIZE = 32
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [4:0] slot_number, [7:5] zero
    input  logic       s_tuser,   // [0] func
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [4:0] slot, [7:5] zero
    output logic [1:0] m_tuser    // [1:0] status
);
    import ospa_pkg::*;

    cmd_t   cmd;
    flags_t flags;
    logic   ctrl_tready;
    logic [4:0] out_slot;

    ospa_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (ctrl_tready),
        .flags    (flags),
        .cmd      (cmd)
    );

    ospa_dpath #(
        .POOL_SIZE (POOL_SIZE)
    ) u_dpath (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cmd            (cmd),
        .flags          (flags),
        .in_func        (s_tuser),
        .in_slot_number (s_tdata[4:0]),
        .out_valid      (m_tvalid),
        .out_ready      (m_tready),
        .out_status     (m_tuser),
        .out_slot       (out_slot)
    );

    assign s_tready = ctrl_tready;
    assign m_tdata  = {3'd0, out_slot};

endmodule
